FILE: rtl/column_transition_search_assert.svh
// Assertion macros for the RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef COLUMN_TRANSITION_SEARCH_ASSERT_SVH
`define COLUMN_TRANSITION_SEARCH_ASSERT_SVH

// Expression must hold at every clock edge outside reset.
`define CTS_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/cts_pkg.sv
package cts_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int PIX_W      = 8;
  localparam int COORD_W    = 10;
  localparam int HSUM_W     = 11;
  localparam int TOT_W      = 12;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int COL_ST_W   = COORD_W + 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEAM_LEFT       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEAM_RIGHT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_ROW       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_ROW        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND_TOP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_LEVEL = 3'd5;

  // reset values
  localparam logic [COORD_W-1:0] RST_SEAM_LEFT       = 10'd0;
  localparam logic [COORD_W-1:0] RST_SEAM_RIGHT      = 10'd1023;
  localparam logic [COORD_W-1:0] RST_START_ROW       = 10'd0;
  localparam logic [COORD_W-1:0] RST_STOP_ROW        = 10'd1023;
  localparam logic               RST_BACKGROUND_TOP  = 1'b1;
  localparam logic [PIX_W-1:0]   RST_THRESHOLD_LEVEL = 8'd50;

  typedef struct packed {
    logic [COORD_W-1:0] seam_left;
    logic [COORD_W-1:0] seam_right;
    logic [COORD_W-1:0] start_row;
    logic [COORD_W-1:0] stop_row;
    logic               background_top;
    logic [PIX_W-1:0]   threshold_level;
  } cfg_t;

  // pixel word handed from the front stage to the update stage
  typedef struct packed {
    logic               has_col;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] row;
    logic [HSUM_W-1:0]  hsum;
  } item_t;

  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
  } rd_req_t;

  typedef struct packed {
    logic               found;
    logic [COORD_W-1:0] hit_row;
  } col_state_t;

endpackage

FILE: rtl/cts_in_if.sv
interface cts_in_if import cts_pkg::*;;
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   pixel;
  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] row;

  modport source (output valid, output pixel, output col, output row, input ready);
  modport sink   (input valid, input pixel, input col, input row, output ready);
endinterface

FILE: rtl/cts_out_if.sv
interface cts_out_if import cts_pkg::*;;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] column;
  logic               found;
  logic [COORD_W-1:0] hit_row;
  logic               last;

  modport source (output valid, output column, output found, output hit_row, output last,
                  input ready);
  modport sink   (input valid, input column, input found, input hit_row, input last,
                  output ready);
endinterface

FILE: rtl/cts_ram.sv
module cts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/cts_front.sv
module cts_front import cts_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [PIX_W-1:0]   pixel,
  input  logic [COORD_W-1:0] col,
  input  logic [COORD_W-1:0] row,
  input  logic               advance,
  output rd_req_t            rd_req,
  output logic               lb_we,
  output logic [HSUM_W-1:0]  lb_wdata,
  output item_t              item_r,
  output logic               item_valid_r
);

  logic [PIX_W-1:0]   recent_r [4];
  logic               in_range;
  logic               take;
  logic               has_col;
  logic [COORD_W-1:0] x;
  logic [HSUM_W-1:0]  hsum;
  item_t              item_nxt;

  assign in_range = (int'(col) < MAX_WIDTH) && (int'(row) < MAX_HEIGHT);
  assign take     = accept && in_range;
  assign has_col  = col >= COORD_W'(2);
  assign x        = col - COORD_W'(2);
  assign hsum     = HSUM_W'(pixel) + HSUM_W'(recent_r[0]) + HSUM_W'(recent_r[1])
                  + HSUM_W'(recent_r[2]) + HSUM_W'(recent_r[3]);

  assign rd_req.en   = take && has_col;
  assign rd_req.addr = ADDR_W'(x);
  assign lb_we       = take && has_col;
  assign lb_wdata    = hsum;

  assign item_nxt.has_col = has_col;
  assign item_nxt.x       = x;
  assign item_nxt.row     = row;
  assign item_nxt.hsum    = hsum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        recent_r[i] <= '0;
      end
      item_valid_r <= 1'b0;
    end else begin
      if (take) begin
        recent_r[0] <= pixel;
        recent_r[1] <= recent_r[0];
        recent_r[2] <= recent_r[1];
        recent_r[3] <= recent_r[2];
      end
      if (advance) begin
        item_valid_r <= take;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      item_r <= item_nxt;
    end
  end

endmodule

FILE: rtl/cts_update.sv
`include "column_transition_search_assert.svh"

module cts_update import cts_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  item_t               item_r,
  input  logic                item_valid_r,
  input  rd_req_t             rd_req,
  input  logic [HSUM_W-1:0]   lb_rdata,
  input  col_state_t          col_rdata,
  output logic                advance,
  output logic                col_we,
  output logic [ADDR_W-1:0]   col_waddr,
  output col_state_t          col_wdata,
  cts_out_if.source           out_if
);

  logic               byp_hit_r;
  col_state_t         byp_data_r;
  col_state_t         base;
  col_state_t         st_nxt;
  logic [COORD_W:0]   x_ext;
  logic [COORD_W:0]   x_p2;
  logic               lo_ok;
  logic               hi_ok;
  logic               is_last;
  logic [TOT_W-1:0]   total;
  logic [TOT_W-1:0]   thr10;
  logic               row_nz;
  logic [COORD_W-1:0] y_dn;
  logic [COORD_W-1:0] y;
  logic               in_band;
  logic               closing;
  logic               qualifies;
  logic               take_hit;
  logic               emits;

  logic               out_valid_r;
  logic [COORD_W-1:0] out_column_r;
  logic               out_found_r;
  logic [COORD_W-1:0] out_hit_row_r;
  logic               out_last_r;

  assign x_ext   = {1'b0, item_r.x};
  assign x_p2    = x_ext + (COORD_W+1)'(2);
  assign lo_ok   = x_ext >= ({1'b0, cfg.seam_left} + (COORD_W+1)'(2));
  assign hi_ok   = x_p2 <= {1'b0, cfg.seam_right};
  assign is_last = x_p2 == {1'b0, cfg.seam_right};

  assign total = TOT_W'(lb_rdata) + TOT_W'(item_r.hsum);
  assign thr10 = {1'b0, cfg.threshold_level, 3'b000} + {3'b000, cfg.threshold_level, 1'b0};

  assign row_nz    = item_r.row != '0;
  assign y_dn      = item_r.row - COORD_W'(1);
  assign qualifies = row_nz && (total > thr10);

  always_comb begin
    if (cfg.background_top) begin
      y       = y_dn;
      in_band = row_nz && (y_dn >= cfg.start_row) && (y_dn < cfg.stop_row);
      closing = item_r.row == cfg.stop_row;
    end else begin
      y       = item_r.row;
      in_band = row_nz && (item_r.row <= cfg.start_row) && (item_r.row > cfg.stop_row);
      closing = item_r.row == cfg.start_row;
    end
  end

  // row 0 restarts the column; otherwise take the freshest copy
  always_comb begin
    if (!row_nz) begin
      base = '0;
    end else if (byp_hit_r) begin
      base = byp_data_r;
    end else begin
      base = col_rdata;
    end
  end

  // downward search keeps the first hit, upward keeps the latest;
  // columns outside the seams keep their state
  assign take_hit = qualifies && in_band && lo_ok && hi_ok &&
                    (!cfg.background_top || !base.found);

  always_comb begin
    st_nxt = base;
    if (take_hit) begin
      st_nxt.found   = 1'b1;
      st_nxt.hit_row = y;
    end
  end

  assign emits   = item_valid_r && item_r.has_col && lo_ok && hi_ok && closing;
  assign advance = !emits || !out_valid_r || out_if.ready;

  assign col_we    = item_valid_r && item_r.has_col && advance;
  assign col_waddr = ADDR_W'(item_r.x);
  assign col_wdata = st_nxt;

  // a read issued on the edge of a same-entry write sees stale data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_hit_r <= 1'b0;
    end else if (rd_req.en) begin
      byp_hit_r <= col_we && (col_waddr == rd_req.addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      byp_data_r <= col_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emits && advance) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emits && advance) begin
      out_column_r  <= item_r.x;
      out_found_r   <= st_nxt.found;
      out_hit_row_r <= st_nxt.found ? st_nxt.hit_row : '0;
      out_last_r    <= is_last;
    end
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.column  = out_column_r;
  assign out_if.found   = out_found_r;
  assign out_if.hit_row = out_hit_row_r;
  assign out_if.last    = out_last_r;

  `CTS_ASSERT_ALWAYS(a_nofound_row_zero, !out_valid_r || out_found_r || (out_hit_row_r == '0), "row set without a find")
  `CTS_ASSERT_ALWAYS(a_found_sticky, !(col_we && base.found && row_nz) || col_wdata.found, "found bit lost mid-frame")
  `CTS_ASSERT_ALWAYS(a_result_room, !(emits && advance) || !out_valid_r || out_if.ready, "result overwrites pending word")
  `CTS_ASSERT_NEXT(a_bypass_capture, rd_req.en && col_we && (col_waddr == rd_req.addr), byp_hit_r, "same-entry write not forwarded")

endmodule

FILE: rtl/column_transition_search.sv
// Datapath: the closing pixel passes the front-stage item register, then the result word register.
// Throughput: one pixel per clock; the input stalls only when a closing-row pixel meets a
//   result word that the sink has not yet taken (one output register between the sides).
// Reset: rst_n (synchronous) clears the configuration registers, pipeline valids and the pixel shift register.
//   Line-buffer and column-state RAMs are not cleared; row 0 rebuilds the column state.
module column_transition_search import cts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  cts_in_if.sink                in_if,
  cts_out_if.source             out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Two-stage pipeline around two RAMs with registered reads:
  //   front  : 5-pixel horizontal sum, line-buffer read+write at column x = col-2,
  //            column-state read at x.
  //   update : 2-row window sum, band/threshold test, read-modify-write of the
  //            column state (with a one-word bypass for back-to-back same column),
  //            result word into the output register on the closing row.

  cfg_t                cfg_r;
  logic                accept;
  logic                advance;
  rd_req_t             rd_req;
  logic                lb_we;
  logic [HSUM_W-1:0]   lb_wdata;
  logic [HSUM_W-1:0]   lb_rdata;
  item_t               item_r;
  logic                item_valid_r;
  logic                col_we;
  logic [ADDR_W-1:0]   col_waddr;
  col_state_t          col_wdata;
  col_state_t          col_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.seam_left       <= RST_SEAM_LEFT;
      cfg_r.seam_right      <= RST_SEAM_RIGHT;
      cfg_r.start_row       <= RST_START_ROW;
      cfg_r.stop_row        <= RST_STOP_ROW;
      cfg_r.background_top  <= RST_BACKGROUND_TOP;
      cfg_r.threshold_level <= RST_THRESHOLD_LEVEL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEAM_LEFT:       cfg_r.seam_left       <= cfg_wdata[COORD_W-1:0];
        REG_SEAM_RIGHT:      cfg_r.seam_right      <= cfg_wdata[COORD_W-1:0];
        REG_START_ROW:       cfg_r.start_row       <= cfg_wdata[COORD_W-1:0];
        REG_STOP_ROW:        cfg_r.stop_row        <= cfg_wdata[COORD_W-1:0];
        REG_BACKGROUND_TOP:  cfg_r.background_top  <= cfg_wdata[0];
        REG_THRESHOLD_LEVEL: cfg_r.threshold_level <= cfg_wdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_if.ready = advance;
  assign accept      = in_if.valid && in_if.ready;

  cts_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .pixel        (in_if.pixel),
    .col          (in_if.col),
    .row          (in_if.row),
    .advance      (advance),
    .rd_req       (rd_req),
    .lb_we        (lb_we),
    .lb_wdata     (lb_wdata),
    .item_r       (item_r),
    .item_valid_r (item_valid_r)
  );

  // previous row's horizontal sums, one per column
  cts_ram #(
    .WIDTH (HSUM_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (lb_we),
    .waddr (rd_req.addr),
    .wdata (lb_wdata),
    .re    (rd_req.en),
    .raddr (rd_req.addr),
    .rdata (lb_rdata)
  );

  // per-column found flag and hit row
  cts_ram #(
    .WIDTH (COL_ST_W),
    .DEPTH (MAX_WIDTH)
  ) u_col_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (col_waddr),
    .wdata (col_wdata),
    .re    (rd_req.en),
    .raddr (rd_req.addr),
    .rdata (col_rdata)
  );

  cts_update u_update (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .item_r       (item_r),
    .item_valid_r (item_valid_r),
    .rd_req       (rd_req),
    .lb_rdata     (lb_rdata),
    .col_rdata    (col_rdata),
    .advance      (advance),
    .col_we       (col_we),
    .col_waddr    (col_waddr),
    .col_wdata    (col_wdata),
    .out_if       (out_if)
  );

endmodule

FILE: tb/column_transition_search_test.sv
module column_transition_search_test;
  import cts_pkg::*;

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 5;
  localparam int RANDOM_ITEMS  = 660;
  // a result word is registered after its pixel leaves the front stage; settle before touching registers
  localparam int SETTLE_CYCLES = 6;
  localparam int TAIL_CYCLES   = 20;
  localparam int LONG_HOLD     = 400;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int MAX_REPORTS   = 10;
  // columns that row 0 fills at the start: the low ones and the top few
  localparam int PRIME_COLS    = 64;
  localparam int PRIME_TAIL    = 8;

  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic               found;
    logic [COORD_W-1:0] hit_row;
    logic               last;
  } column_result_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } pixel_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  cts_in_if  pix_ch ();
  cts_out_if res_ch ();

  column_transition_search u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (pix_ch),
    .out_if    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // ------------------------------------------------------------------
  // Search model: shadow registers plus our own copy of the pixel shift
  // register, the line of 5-pixel row sums and the per-column state.
  // ------------------------------------------------------------------
  cfg_t               shadow_cfg;
  logic [PIX_W-1:0]   tap_pixels [4];
  logic [HSUM_W-1:0]  row_sums [MAX_WIDTH];
  logic               col_found [MAX_WIDTH];
  logic [COORD_W-1:0] col_hit_row [MAX_WIDTH];

  column_result_t column_results_due [$];
  pixel_word_t    pixel_backlog [$];

  int  pushed_words;
  int  accepted_words;
  int  error_count;
  int  send_gap;
  int  stall_left;
  int  hold_left;
  bit  long_hold_req;
  bit  no_idle;
  int  cycle_count;

  pixel_word_t    drv_word;
  column_result_t got_word;
  column_result_t want_word;

  // One accepted pixel word: update the window state and queue the column
  // result if this pixel sits on the band's closing row.
  function automatic void track_pixel(pixel_word_t w);
    int hsum, prev, total, x, y, lo, hi;
    bit qualifies, in_band, closing;
    column_result_t res;
    hsum = int'(w.pixel) + int'(tap_pixels[0]) + int'(tap_pixels[1]) +
           int'(tap_pixels[2]) + int'(tap_pixels[3]);
    tap_pixels[3] = tap_pixels[2];
    tap_pixels[2] = tap_pixels[1];
    tap_pixels[1] = tap_pixels[0];
    tap_pixels[0] = w.pixel;
    if (w.col < 2) return;
    // the 5-pixel sum is centered two columns left of the current pixel
    x = int'(w.col) - 2;
    prev = int'(row_sums[x]);
    row_sums[x] = hsum[HSUM_W-1:0];
    if (w.row == 0) begin
      col_found[x]   = 1'b0;
      col_hit_row[x] = '0;
    end
    lo = int'(shadow_cfg.seam_left) + 2;
    hi = int'(shadow_cfg.seam_right) - 2;
    if (x < lo || x > hi) return;
    total = prev + hsum;
    qualifies = (w.row >= 1) && (total > 10 * int'(shadow_cfg.threshold_level));
    if (shadow_cfg.background_top) begin
      // window y spans rows y and y+1; first hit going down wins
      y = int'(w.row) - 1;
      in_band = (w.row >= 1) && (y >= int'(shadow_cfg.start_row)) &&
                (y < int'(shadow_cfg.stop_row));
      if (qualifies && in_band && !col_found[x]) begin
        col_found[x]   = 1'b1;
        col_hit_row[x] = y[COORD_W-1:0];
      end
      closing = (w.row == shadow_cfg.stop_row);
    end else begin
      // window y spans rows y-1 and y; last hit in raster order wins
      y = int'(w.row);
      in_band = (w.row >= 1) && (y <= int'(shadow_cfg.start_row)) &&
                (y > int'(shadow_cfg.stop_row));
      if (qualifies && in_band) begin
        col_found[x]   = 1'b1;
        col_hit_row[x] = y[COORD_W-1:0];
      end
      closing = (w.row == shadow_cfg.start_row);
    end
    if (!closing) return;
    res.column  = x[COORD_W-1:0];
    res.found   = col_found[x];
    res.hit_row = col_found[x] ? col_hit_row[x] : '0;
    res.last    = (x == hi);
    column_results_due.insert(column_results_due.size(), res);
  endfunction

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  // Scattered column among those filled on row 0.
  function automatic int pick_col();
    if ($urandom_range(0, 3) == 0)
      return $urandom_range(MAX_WIDTH - PRIME_TAIL, MAX_WIDTH - 1);
    return $urandom_range(0, PRIME_COLS - 1);
  endfunction

  function automatic cfg_t make_cfg(int sl, int sr, int st, int sp, bit bg, int thr);
    cfg_t c;
    c.seam_left       = COORD_W'(sl);
    c.seam_right      = COORD_W'(sr);
    c.start_row       = COORD_W'(st);
    c.stop_row        = COORD_W'(sp);
    c.background_top  = bg;
    c.threshold_level = PIX_W'(thr);
    return c;
  endfunction

  // Register set for one random frame; mostly a band and a column range
  // that fit the frame, sometimes empty ones or the register extremes.
  function automatic cfg_t random_cfg(int width, int height, bit bg);
    int sl, sr, st, sp, thr, r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      sl = 0;
      sr = 1023;
    end else if (r == 1) begin
      sl = $urandom_range(0, 1023);
      sr = $urandom_range(0, (sl + 3 > 1023) ? 1023 : sl + 3);
    end else if (r == 2) begin
      sl = 1023;
      sr = 0;
    end else begin
      sl = $urandom_range(0, width / 3);
      sr = $urandom_range(sl + 4, width + 3);
    end
    r = $urandom_range(0, 9);
    if (bg) begin
      if (r == 0) begin
        st = 0;
        sp = 1023;
      end else if (r == 1) begin
        sp = $urandom_range(0, height - 1);
        st = $urandom_range(sp, 1023);
      end else begin
        sp = $urandom_range(1, height - 1);
        st = $urandom_range(0, sp - 1);
      end
    end else begin
      if (r == 0) begin
        st = 1023;
        sp = 0;
      end else if (r == 1) begin
        st = $urandom_range(0, height - 1);
        sp = $urandom_range(st, 1023);
      end else begin
        st = $urandom_range(1, height - 1);
        sp = $urandom_range(0, st - 1);
      end
    end
    r = $urandom_range(0, 9);
    thr = (r == 0) ? 0 : (r == 1) ? 255 : $urandom_range(30, 160);
    return make_cfg(sl, sr, st, sp, bg, thr);
  endfunction

  task automatic send_pixel(int pix, int col, int row);
    pixel_word_t w;
    w.pixel = PIX_W'(pix);
    w.col   = COORD_W'(col);
    w.row   = COORD_W'(row);
    pixel_backlog.insert(pixel_backlog.size(), w);
    pushed_words++;
  endtask

  // Raster frame from row 0. Unless textured, a dark background turns into
  // bright material along a jagged line; budget cuts the frame short.
  task automatic send_frame(int width, int height, bit material_below, bit textured,
                            int budget);
    int base, t, count;
    bit material;
    base  = $urandom_range(0, height - 1);
    count = 0;
    for (int r = 0; r < height; r++) begin
      for (int c = 0; c < width; c++) begin
        if (count == budget) return;
        t = base + ((c * 5 + base) % 3) - 1;
        material = material_below ? (r >= t) : (r <= t);
        if (textured)
          send_pixel($urandom_range(0, 255), c, r);
        else if (material)
          send_pixel($urandom_range(130, 255), c, r);
        else
          send_pixel($urandom_range(0, 80), c, r);
        count++;
      end
    end
  endtask

  // All words taken and all results back, then let the pipeline drain.
  task automatic wait_idle();
    @(posedge clk);
    while (accepted_words != pushed_words || column_results_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
  endtask

  task automatic program_regs(cfg_t c);
    wait_idle();
    shadow_cfg = c;
    write_reg(REG_SEAM_LEFT,       c.seam_left);
    write_reg(REG_SEAM_RIGHT,      c.seam_right);
    write_reg(REG_START_ROW,       c.start_row);
    write_reg(REG_STOP_ROW,        c.stop_row);
    write_reg(REG_BACKGROUND_TOP,  c.background_top);
    write_reg(REG_THRESHOLD_LEVEL, c.threshold_level);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // ------------------------------------------------------------------
  // Pixel driver: on acceptance the word goes through the model; a new
  // word is only put up once the bus is free.
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      pix_ch.valid <= 1'b0;
    end else begin
      if (pix_ch.valid && pix_ch.ready) begin
        drv_word.pixel = pix_ch.pixel;
        drv_word.col   = pix_ch.col;
        drv_word.row   = pix_ch.row;
        track_pixel(drv_word);
        accepted_words++;
      end
      if (!pix_ch.valid || pix_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          pix_ch.valid <= 1'b0;
        end else if (pixel_backlog.size() > 0) begin
          drv_word = pixel_backlog.pop_front();
          pix_ch.valid <= 1'b1;
          pix_ch.pixel <= drv_word.pixel;
          pix_ch.col   <= drv_word.col;
          pix_ch.row   <= drv_word.row;
          send_gap = pick_gap();
        end else begin
          pix_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Result monitor: checks each taken word against the oldest expected
  // column result; ready stalls at random, plus one long hold on request.
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got_word.column  = res_ch.column;
        got_word.found   = res_ch.found;
        got_word.hit_row = res_ch.hit_row;
        got_word.last    = res_ch.last;
        if (column_results_due.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("unexpected result word: column %0d found %0b hit_row %0d last %0b",
                     got_word.column, got_word.found, got_word.hit_row, got_word.last);
        end else begin
          want_word = column_results_due.pop_front();
          if (got_word.column !== want_word.column || got_word.found !== want_word.found ||
              got_word.hit_row !== want_word.hit_row || got_word.last !== want_word.last) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("result mismatch: expected column %0d found %0b hit_row %0d last %0b, %s",
                       want_word.column, want_word.found, want_word.hit_row, want_word.last,
                       $sformatf("got column %0d found %0b hit_row %0d last %0b",
                                 got_word.column, got_word.found, got_word.hit_row,
                                 got_word.last));
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
        res_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // ------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------
  initial begin
    cfg_t cfg;
    int   w, h, n, random_sent, phase;
    bit   bg;

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    pix_ch.valid = 1'b0;
    pix_ch.pixel = '0;
    pix_ch.col   = '0;
    pix_ch.row   = '0;
    res_ch.ready = 1'b0;

    pushed_words   = 0;
    accepted_words = 0;
    error_count    = 0;
    send_gap       = 0;
    stall_left     = 0;
    hold_left      = 0;
    long_hold_req  = 1'b0;
    no_idle        = 1'b0;
    shadow_cfg     = make_cfg(RST_SEAM_LEFT, RST_SEAM_RIGHT, RST_START_ROW, RST_STOP_ROW,
                              RST_BACKGROUND_TOP, RST_THRESHOLD_LEVEL);
    for (int i = 0; i < 4; i++) tap_pixels[i] = '0;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      row_sums[i]    = '0;
      col_found[i]   = 1'b0;
      col_hit_row[i] = '0;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Row 0 at reset settings over every column that later words use: fills
    // those line-buffer entries and clears those columns, so any later word
    // reads written entries only.
    program_regs(make_cfg(RST_SEAM_LEFT, RST_SEAM_RIGHT, RST_START_ROW, RST_STOP_ROW,
                          RST_BACKGROUND_TOP, RST_THRESHOLD_LEVEL));
    for (int c = 0; c < PRIME_COLS; c++) send_pixel((c % 2) ? 255 : 0, c, 0);
    for (int c = MAX_WIDTH - PRIME_TAIL; c < MAX_WIDTH; c++)
      send_pixel((c % 2) ? 255 : 0, c, 0);

    // --- directed words ---
    // top threshold: nothing qualifies, rightmost column carries last
    program_regs(make_cfg(0, 1023, 0, 1, 1, 255));
    send_pixel(255, 1023, 1);
    send_pixel(0, 0, 1);
    send_pixel(255, 1, 1);
    // zero threshold, narrow seams: hits on the first band row
    program_regs(make_cfg(8, 20, 0, 1, 1, 0));
    send_pixel(255, 12, 1);
    send_pixel(0, 20, 1);
    // closing on row 0: no window above it, band empty
    program_regs(make_cfg(0, 1023, 0, 0, 1, 0));
    send_pixel(255, 30, 0);
    // upward search: the later window nearer start_row wins
    program_regs(make_cfg(0, 1023, 3, 1, 0, 0));
    send_pixel(200, 40, 2);
    send_pixel(200, 40, 3);
    // upward search with empty band
    program_regs(make_cfg(0, 1023, 1, 1, 0, 0));
    send_pixel(255, 50, 1);
    // column range empty
    program_regs(make_cfg(600, 100, 0, 5, 1, 0));
    send_pixel(255, 20, 5);
    send_pixel(255, 60, 5);
    program_regs(make_cfg(1023, 1023, 0, 1023, 1, 0));
    send_pixel(255, 1023, 1023);
    // last row of the coordinate range, both directions
    program_regs(make_cfg(0, 1023, 1023, 1023, 0, 0));
    send_pixel(255, 1023, 1023);
    program_regs(make_cfg(0, 1023, 1022, 1023, 1, 0));
    send_pixel(0, 1023, 1023);

    // --- random frames and noise ---
    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      bg = $urandom_range(0, 1);
      w  = $urandom_range(6, 28);
      h  = $urandom_range(2, 8);
      if (phase == 2) begin
        // many results on one row while the sink holds off: the output
        // register fills and the pixel side has to stall
        bg = 1'b1;
        w  = 24;
        h  = 5;
        cfg = make_cfg(0, 1023, 0, 3, 1, 100);
      end else begin
        cfg = random_cfg(w, h, bg);
      end
      program_regs(cfg);
      no_idle = ($urandom_range(0, 4) == 0);
      if (phase == 2) begin
        no_idle = 1'b0;
        long_hold_req = 1'b1;
        send_frame(w, h, bg, 1'b0, w * h);
        random_sent += w * h;
      end else if ($urandom_range(0, 5) == 0) begin
        // noise: scattered words over the filled columns and any row
        n = $urandom_range(16, 40);
        for (int i = 0; i < n; i++)
          send_pixel($urandom_range(0, 255), pick_col(), $urandom_range(0, 1023));
        random_sent += n;
      end else begin
        // now and then a frame broken off before its end
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, w * h) : w * h;
        send_frame(w, h, bg, ($urandom_range(0, 5) == 0), n);
        random_sent += n;
      end
      phase++;
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && column_results_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
